### sv/ppf_pkg.sv
// Shared types, constants and helpers for the planar pixel fetch block.
`default_nettype none

package ppf_pkg;

    localparam int unsigned MEM_BYTES   = 262144;
    localparam int unsigned MEM_AW      = $clog2(MEM_BYTES);
    localparam int unsigned MAX_PLANES  = 8;
    localparam int unsigned PLANE_W     = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int unsigned ADDR_W      = 25;
    localparam int unsigned PROD_W      = 18;
    localparam int unsigned NPROD_W     = 22;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [ADDR_W-1:0] MEM_LIMIT = ADDR_W'(MEM_BYTES);

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    localparam logic [2:0] LAYOUT_SEPARATE   = 3'd0;
    localparam logic [2:0] LAYOUT_INTERLEAVE = 3'd1;
    localparam logic [2:0] LAYOUT_SPRITE     = 3'd2;
    localparam logic [2:0] LAYOUT_PACKED_A   = 3'd3;
    localparam logic [2:0] LAYOUT_PACKED_B   = 3'd4;

    localparam logic [2:0] CFG_LAYOUT_MODE  = 3'd0;
    localparam logic [2:0] CFG_PLANE_COUNT  = 3'd1;
    localparam logic [2:0] CFG_ROW_BYTES    = 3'd2;
    localparam logic [2:0] CFG_PICTURE_ROWS = 3'd3;
    localparam logic [2:0] CFG_SKIP_BYTES   = 3'd4;
    localparam logic [2:0] CFG_PLANE_FLAGS  = 3'd5;
    localparam logic [2:0] CFG_PLANE_ORDER  = 3'd6;
    localparam logic [2:0] CFG_DATA_SIZE    = 3'd7;

    typedef struct packed {
        logic [2:0]  layout_mode;
        logic [3:0]  plane_count;
        logic [7:0]  row_bytes;
        logic [9:0]  picture_rows;
        logic [15:0] skip_bytes;
        logic [1:0]  plane_flags;
        logic [23:0] plane_order;
        logic [18:0] data_size;
    } t_cfg;

    typedef struct packed {
        logic              kind;
        logic [17:0]       load_address;
        logic [7:0]        load_byte;
        logic [ADDR_W-1:0] common;
        logic [ADDR_W-1:0] step;
        logic [ADDR_W-1:0] jump;
        logic [2:0]        xlow;
    } t_qent;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ISSUE,
        BK_DRAIN,
        BK_EMIT
    } t_back_state;

    function automatic logic [3:0] planes_eff(input logic [3:0] count);
        if (count > 4'(MAX_PLANES)) begin
            return 4'(MAX_PLANES);
        end
        return count;
    endfunction

endpackage

`default_nettype wire

### sv/ppf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ppf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### sv/ppf_front.sv
// Front end: accept items, form per-pixel base address and plane strides.
`default_nettype none

module ppf_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ppf_pkg::t_cfg i_cfg,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic          i_kind,
    input  wire logic [17:0]   i_load_address,
    input  wire logic [7:0]    i_load_byte,
    input  wire logic [17:0]   i_picture_base,
    input  wire logic [10:0]   i_pixel_x,
    input  wire logic [9:0]    i_pixel_y,
    output logic               o_push,
    output ppf_pkg::t_qent     o_entry,
    input  wire logic          i_full
);

    logic                           r_s1_v, r_s2_v, r_s3_v;
    logic                           r_s1_kind, r_s2_kind;
    logic [17:0]                    r_s1_laddr, r_s2_laddr;
    logic [7:0]                     r_s1_lbyte, r_s2_lbyte;
    logic [17:0]                    r_s1_base, r_s2_base;
    logic [10:0]                    r_s1_x, r_s2_x;
    logic [9:0]                     r_s1_y;
    logic [ppf_pkg::PROD_W-1:0]     r_s2_yr, r_s2_rr;
    ppf_pkg::t_qent                 r_s3;

    logic                           w_adv;
    logic [ppf_pkg::PROD_W-1:0]     w_yr, w_rr;
    logic [ppf_pkg::NPROD_W-1:0]    w_nyr;
    logic [3:0]                     w_n;
    logic [ppf_pkg::ADDR_W-1:0]     w_skip, w_xbyte, w_xquad, w_yr2, w_base;
    ppf_pkg::t_qent                 w_ent;

    assign w_adv      = !r_s3_v || !i_full;
    assign o_in_ready = w_adv;
    assign o_push     = r_s3_v && !i_full;
    assign o_entry    = r_s3;

    assign w_yr = ppf_pkg::PROD_W'(r_s1_y) * ppf_pkg::PROD_W'(i_cfg.row_bytes);
    assign w_rr = ppf_pkg::PROD_W'(i_cfg.picture_rows) * ppf_pkg::PROD_W'(i_cfg.row_bytes);
    assign w_n  = ppf_pkg::planes_eff(i_cfg.plane_count);
    assign w_nyr = ppf_pkg::NPROD_W'(w_n) * ppf_pkg::NPROD_W'(r_s2_yr);

    assign w_skip  = i_cfg.plane_flags[0] ? ppf_pkg::ADDR_W'(i_cfg.skip_bytes) : '0;
    assign w_xbyte = ppf_pkg::ADDR_W'(r_s2_x[10:3]);
    assign w_xquad = ppf_pkg::ADDR_W'(r_s2_x[10:2]);
    assign w_yr2   = ppf_pkg::ADDR_W'({r_s2_yr, 1'b0});
    assign w_base  = ppf_pkg::ADDR_W'(r_s2_base);

    always_comb begin
        w_ent              = '0;
        w_ent.kind         = r_s2_kind;
        w_ent.load_address = r_s2_laddr;
        w_ent.load_byte    = r_s2_lbyte;
        w_ent.xlow         = r_s2_x[2:0];
        w_ent.jump         = ppf_pkg::ADDR_W'({r_s2_rr, 1'b0}) + (w_skip << 1);
        case (i_cfg.layout_mode)
            ppf_pkg::LAYOUT_SEPARATE: begin
                w_ent.common = w_base + w_xbyte + ppf_pkg::ADDR_W'(r_s2_yr);
                w_ent.step   = ppf_pkg::ADDR_W'(r_s2_rr) + w_skip;
            end
            ppf_pkg::LAYOUT_INTERLEAVE: begin
                w_ent.common = w_base + w_xbyte + ppf_pkg::ADDR_W'(w_nyr);
                w_ent.step   = ppf_pkg::ADDR_W'(i_cfg.row_bytes) + w_skip;
            end
            ppf_pkg::LAYOUT_SPRITE: begin
                w_ent.common = w_base + w_xbyte + w_yr2;
                w_ent.step   = ppf_pkg::ADDR_W'(i_cfg.row_bytes) + w_skip;
            end
            ppf_pkg::LAYOUT_PACKED_A: begin
                w_ent.common = w_base + (w_xbyte << 1) + w_yr2;
                w_ent.step   = ppf_pkg::ADDR_W'(1) + w_skip;
            end
            ppf_pkg::LAYOUT_PACKED_B: begin
                w_ent.common = w_base + w_xquad + w_yr2;
                w_ent.step   = w_skip;
            end
            default: begin
                w_ent.common = w_base;
                w_ent.step   = w_skip;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (w_adv) begin
            r_s1_v <= i_in_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_kind  <= i_kind;
            r_s1_laddr <= i_load_address;
            r_s1_lbyte <= i_load_byte;
            r_s1_base  <= i_picture_base;
            r_s1_x     <= i_pixel_x;
            r_s1_y     <= i_pixel_y;
            r_s2_kind  <= r_s1_kind;
            r_s2_laddr <= r_s1_laddr;
            r_s2_lbyte <= r_s1_lbyte;
            r_s2_base  <= r_s1_base;
            r_s2_x     <= r_s1_x;
            r_s2_yr    <= w_yr;
            r_s2_rr    <= w_rr;
            r_s3       <= w_ent;
        end
    end

endmodule

`default_nettype wire

### sv/ppf_queue.sv
// Short queue between the front end and the memory sequencer.
`default_nettype none

module ppf_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ppf_pkg::t_qent i_entry,
    output logic                o_full,
    output logic                o_valid,
    output ppf_pkg::t_qent      o_entry,
    input  wire logic           i_pop
);

    ppf_pkg::t_qent                r_mem [ppf_pkg::QUEUE_DEPTH];
    logic [ppf_pkg::QUEUE_AW-1:0]  r_wptr, r_rptr;
    logic [ppf_pkg::QUEUE_AW:0]    r_count;

    assign o_full  = r_count == (ppf_pkg::QUEUE_AW+1)'(ppf_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_entry = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

### sv/ppf_back.sv
// Back end: write loads, read one plane byte a cycle, assemble the colour index.
`default_nettype none

module ppf_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire ppf_pkg::t_cfg              i_cfg,
    input  wire logic                       i_q_valid,
    input  wire ppf_pkg::t_qent             i_q_entry,
    output logic                            o_q_pop,
    output logic                            o_ram_we,
    output logic [ppf_pkg::MEM_AW-1:0]      o_ram_waddr,
    output logic [7:0]                      o_ram_wdata,
    output logic [ppf_pkg::MEM_AW-1:0]      o_ram_raddr,
    input  wire logic [7:0]                 i_ram_rdata,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [7:0]                      o_colour_index
);

    ppf_pkg::t_back_state          r_state, n_state;
    logic [ppf_pkg::ADDR_W-1:0]    r_common, r_step, r_jump, r_acc, n_acc;
    logic [2:0]                    r_xlow;
    logic [ppf_pkg::PLANE_W-1:0]   r_i;
    logic [7:0]                    r_slot;
    logic                          r_rd_v, r_rd_ok;
    logic [2:0]                    r_rd_pos, r_rd_slot;
    logic                          r_out_v;
    logic [7:0]                    r_colour;

    logic [3:0]                    w_n;
    logic                          w_last, w_skip_item, w_emit, w_ok;
    logic [ppf_pkg::ADDR_W-1:0]    w_addr, w_laddr;
    logic [2:0]                    w_pos, w_dst;
    logic [7:0]                    w_colour;

    assign w_n    = ppf_pkg::planes_eff(i_cfg.plane_count);
    assign w_last = {1'b0, 3'(r_i)} == (w_n - 4'd1);
    assign w_skip_item = (i_cfg.layout_mode > ppf_pkg::LAYOUT_PACKED_B) || (w_n == 4'd0);

    assign w_addr = r_common + r_acc
                  + ((i_cfg.layout_mode == ppf_pkg::LAYOUT_PACKED_B)
                     ? ppf_pkg::ADDR_W'(3'(r_i) >> 1) : '0);
    assign w_pos  = (i_cfg.layout_mode == ppf_pkg::LAYOUT_PACKED_B)
                  ? ~{r_i[0], r_xlow[1:0]} : ~r_xlow;
    assign w_dst  = i_cfg.plane_flags[1] ? 3'(w_n - 4'd1 - 4'(r_i)) : 3'(r_i);
    assign w_ok   = (w_addr < ppf_pkg::ADDR_W'(i_cfg.data_size))
                  && (w_addr < ppf_pkg::MEM_LIMIT);
    assign n_acc  = ((i_cfg.layout_mode == ppf_pkg::LAYOUT_SPRITE) && (3'(r_i) == 3'd1))
                  ? r_jump : r_acc + r_step;
    assign w_laddr = ppf_pkg::ADDR_W'(i_q_entry.load_address);

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            w_colour[b] = (4'(b) < w_n) && r_slot[i_cfg.plane_order[3*b +: 3]];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ppf_pkg::BK_IDLE: begin
                if (i_q_valid && i_q_entry.kind == ppf_pkg::KIND_FETCH) begin
                    n_state = w_skip_item ? ppf_pkg::BK_EMIT : ppf_pkg::BK_ISSUE;
                end
            end
            ppf_pkg::BK_ISSUE: begin
                if (w_last) begin
                    n_state = ppf_pkg::BK_DRAIN;
                end
            end
            ppf_pkg::BK_DRAIN: begin
                n_state = ppf_pkg::BK_EMIT;
            end
            ppf_pkg::BK_EMIT: begin
                if (w_emit) begin
                    n_state = ppf_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = ppf_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_q_pop     = (r_state == ppf_pkg::BK_IDLE) && i_q_valid;
        o_ram_we    = o_q_pop && (i_q_entry.kind == ppf_pkg::KIND_LOAD)
                    && (w_laddr < ppf_pkg::MEM_LIMIT);
        o_ram_waddr = w_laddr[ppf_pkg::MEM_AW-1:0];
        o_ram_wdata = i_q_entry.load_byte;
        o_ram_raddr = w_addr[ppf_pkg::MEM_AW-1:0];
        w_emit      = (r_state == ppf_pkg::BK_EMIT) && (!r_out_v || i_out_ready);
    end

    assign o_out_valid    = r_out_v;
    assign o_colour_index = r_colour;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppf_pkg::BK_IDLE;
            r_rd_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= r_state == ppf_pkg::BK_ISSUE;
            if (w_emit) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_entry.kind == ppf_pkg::KIND_FETCH) begin
            r_common <= i_q_entry.common;
            r_step   <= i_q_entry.step;
            r_jump   <= i_q_entry.jump;
            r_xlow   <= i_q_entry.xlow;
            r_i      <= '0;
            r_acc    <= '0;
            r_slot   <= '0;
        end else begin
            if (r_rd_v) begin
                r_slot[r_rd_slot] <= r_rd_ok & i_ram_rdata[r_rd_pos];
            end
            if (r_state == ppf_pkg::BK_ISSUE) begin
                r_i <= r_i + 1'b1;
                r_acc <= n_acc;
            end
        end
        if (r_state == ppf_pkg::BK_ISSUE) begin
            r_rd_pos  <= w_pos;
            r_rd_slot <= w_dst;
            r_rd_ok   <= w_ok;
        end
        if (w_emit) begin
            r_colour <= w_colour;
        end
    end

endmodule

`default_nettype wire

### sv/planar_pixel_fetch.sv
// Top level of the planar pixel fetch block: configuration registers and wiring.
//
// Input channel (i_in_valid / o_in_ready) carries load and fetch items; a load
// writes one byte of the image memory, a fetch yields one colour index on the
// output channel (o_out_valid / i_out_ready). Configuration registers are
// written over i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data; the
// port is always ready and must only be used while the block is idle.
// A three-stage front end forms the pixel address terms and hands items to a
// four-entry queue; the back end drains it. A load is written to the image
// memory as the back end pops it. For a fetch the back end issues one memory
// read per plane on the RAM's single read port (none when the layout mode is
// invalid or the plane count is zero), waits for the last read to return,
// then delivers the colour index.
// Reset returns the registers to their defaults and empties the pipeline; the
// image memory holds no defined value until written.
// When the receiver stalls, the finished colour waits in the output register,
// the back end holds the next result, and the queue and front end keep
// taking items until the queue fills.
`default_nettype none

module planar_pixel_fetch (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_kind,
    input  wire logic [17:0] i_load_address,
    input  wire logic [7:0]  i_load_byte,
    input  wire logic [17:0] i_picture_base,
    input  wire logic [10:0] i_pixel_x,
    input  wire logic [9:0]  i_pixel_y,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_colour_index
);

    ppf_pkg::t_cfg                  r_cfg;
    logic                           w_push, w_full, w_q_valid, w_pop;
    ppf_pkg::t_qent                 w_push_ent, w_head;
    logic                           w_we;
    logic [ppf_pkg::MEM_AW-1:0]     w_waddr, w_raddr;
    logic [7:0]                     w_wdata, w_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.layout_mode  <= 3'd0;
            r_cfg.plane_count  <= 4'd1;
            r_cfg.row_bytes    <= 8'd40;
            r_cfg.picture_rows <= 10'd200;
            r_cfg.skip_bytes   <= 16'd0;
            r_cfg.plane_flags  <= 2'd0;
            r_cfg.plane_order  <= 24'd16434824;
            r_cfg.data_size    <= 19'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ppf_pkg::CFG_LAYOUT_MODE:  r_cfg.layout_mode  <= i_cfg_data[2:0];
                ppf_pkg::CFG_PLANE_COUNT:  r_cfg.plane_count  <= i_cfg_data[3:0];
                ppf_pkg::CFG_ROW_BYTES:    r_cfg.row_bytes    <= i_cfg_data[7:0];
                ppf_pkg::CFG_PICTURE_ROWS: r_cfg.picture_rows <= i_cfg_data[9:0];
                ppf_pkg::CFG_SKIP_BYTES:   r_cfg.skip_bytes   <= i_cfg_data[15:0];
                ppf_pkg::CFG_PLANE_FLAGS:  r_cfg.plane_flags  <= i_cfg_data[1:0];
                ppf_pkg::CFG_PLANE_ORDER:  r_cfg.plane_order  <= i_cfg_data;
                ppf_pkg::CFG_DATA_SIZE:    r_cfg.data_size    <= i_cfg_data[18:0];
                default: begin
                end
            endcase
        end
    end

    ppf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_load_address (i_load_address),
        .i_load_byte    (i_load_byte),
        .i_picture_base (i_picture_base),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .o_push         (w_push),
        .o_entry        (w_push_ent),
        .i_full         (w_full)
    );

    ppf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_ent),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_entry (w_head),
        .i_pop   (w_pop)
    );

    ppf_ram #(
        .WIDTH (8),
        .DEPTH (ppf_pkg::MEM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ppf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (w_q_valid),
        .i_q_entry      (w_head),
        .o_q_pop        (w_pop),
        .o_ram_we       (w_we),
        .o_ram_waddr    (w_waddr),
        .o_ram_wdata    (w_wdata),
        .o_ram_raddr    (w_raddr),
        .i_ram_rdata    (w_rdata),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_colour_index (o_colour_index)
    );

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for planar_pixel_fetch: directed and random loads/fetches vs a colour predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    class pixel_scoreboard;
        ppf_pkg::t_cfg regs;
        byte unsigned image [ppf_pkg::MEM_BYTES];
        bit written [ppf_pkg::MEM_BYTES];
        logic [7:0] colour_q [$];
        int errors;

        function new();
            regs = '{layout_mode: ppf_pkg::LAYOUT_SEPARATE, plane_count: 4'd1,
                     row_bytes: 8'd40, picture_rows: 10'd200, skip_bytes: 16'd0,
                     plane_flags: 2'd0, plane_order: 24'hFAC688, data_size: 19'd0};
            errors = 0;
        endfunction

        task report(input string what);
            errors++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        function void write_cfg(input logic [2:0] idx, input logic [23:0] val);
            case (idx)
                ppf_pkg::CFG_LAYOUT_MODE:  regs.layout_mode  = val[2:0];
                ppf_pkg::CFG_PLANE_COUNT:  regs.plane_count  = val[3:0];
                ppf_pkg::CFG_ROW_BYTES:    regs.row_bytes    = val[7:0];
                ppf_pkg::CFG_PICTURE_ROWS: regs.picture_rows = val[9:0];
                ppf_pkg::CFG_SKIP_BYTES:   regs.skip_bytes   = val[15:0];
                ppf_pkg::CFG_PLANE_FLAGS:  regs.plane_flags  = val[1:0];
                ppf_pkg::CFG_PLANE_ORDER:  regs.plane_order  = val[23:0];
                ppf_pkg::CFG_DATA_SIZE:    regs.data_size    = val[18:0];
                default: begin
                end
            endcase
        endfunction

        function int unsigned eff_planes();
            return (regs.plane_count > ppf_pkg::MAX_PLANES) ? ppf_pkg::MAX_PLANES
                                                            : regs.plane_count;
        endfunction

        function bit holds_data(input longint unsigned addr);
            return (addr < longint'(regs.data_size))
                && (addr < longint'(ppf_pkg::MEM_BYTES));
        endfunction

        // byte address and bit position of plane i of one pixel
        function longint unsigned plane_addr(input logic [17:0] base, input logic [10:0] x,
                                             input logic [9:0] y, input int unsigned i,
                                             input int unsigned n, output int unsigned bitpos);
            longint unsigned b = base;
            longint unsigned px = x;
            longint unsigned py = y;
            longint unsigned rb = regs.row_bytes;
            longint unsigned rows = regs.picture_rows;
            longint unsigned line_bits;
            longint unsigned start;
            longint unsigned bitnum;
            line_bits = rb * 8;
            case (regs.layout_mode)
                ppf_pkg::LAYOUT_SEPARATE: begin
                    start = b + rb * rows * i;
                    bitnum = px + py * line_bits;
                end
                ppf_pkg::LAYOUT_INTERLEAVE: begin
                    start = b + rb * i;
                    bitnum = px + n * py * line_bits;
                end
                ppf_pkg::LAYOUT_SPRITE: begin
                    if (i < 2) begin
                        start = b + rb * i;
                    end else begin
                        start = b + rb * (i - 2) + rows * rb * 2;
                    end
                    bitnum = px + 2 * py * line_bits;
                end
                ppf_pkg::LAYOUT_PACKED_A: begin
                    start = b + px / 8 + i;
                    bitnum = px + 2 * py * line_bits;
                end
                default: begin
                    start = b + px / 4 + rb * py * 2;
                    bitnum = i * 4 + px % 4;
                end
            endcase
            if (regs.plane_flags[0]) begin
                start += longint'(regs.skip_bytes) * i;
            end
            bitpos = 7 - int'(bitnum % 8);
            return start + bitnum / 8;
        endfunction

        function logic [7:0] colour_of(input logic [17:0] base, input logic [10:0] x,
                                       input logic [9:0] y);
            logic [7:0] slot = '0;
            logic [7:0] col = '0;
            int unsigned n = eff_planes();
            int unsigned bitpos;
            int unsigned dst;
            longint unsigned a;
            if (regs.layout_mode > ppf_pkg::LAYOUT_PACKED_B) begin
                return '0;
            end
            for (int unsigned i = 0; i < n; i++) begin
                a = plane_addr(base, x, y, i, n, bitpos);
                dst = regs.plane_flags[1] ? (n - 1 - i) : i;
                slot[dst % 8] = holds_data(a) ? image[a][bitpos] : 1'b0;
            end
            for (int unsigned i = 0; i < n; i++) begin
                if (slot[regs.plane_order[3 * i +: 3]]) begin
                    col[i] = 1'b1;
                end
            end
            return col;
        endfunction

        function void note_item(input logic kind, input logic [17:0] la, input logic [7:0] lb,
                                input logic [17:0] base, input logic [10:0] x,
                                input logic [9:0] y);
            if (kind == ppf_pkg::KIND_LOAD) begin
                image[la] = lb;
                written[la] = 1'b1;
            end else begin
                colour_q.push_back(colour_of(base, x, y));
            end
        endfunction

        task check_colour(input logic [7:0] got);
            logic [7:0] want;
            if (colour_q.size() == 0) begin
                report($sformatf("colour_index %0h with no fetch outstanding", got));
            end else begin
                want = colour_q.pop_front();
                if (got !== want) begin
                    report($sformatf("colour_index got %0h expected %0h", got, want));
                end
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_kind = ppf_pkg::KIND_LOAD;
    logic [17:0] i_load_address = '0;
    logic [7:0]  i_load_byte = '0;
    logic [17:0] i_picture_base = '0;
    logic [10:0] i_pixel_x = '0;
    logic [9:0]  i_pixel_y = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_colour_index;

    pixel_scoreboard sb;
    int sent_items = 0;
    bit in_calm = 1'b0;
    bit out_calm = 1'b0;
    int ready_run = 0;

    planar_pixel_fetch dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_load_address (i_load_address),
        .i_load_byte    (i_load_byte),
        .i_picture_base (i_picture_base),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_colour_index (o_colour_index)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (out_calm) begin
            i_out_ready <= 1'b1;
        end else if (ready_run > 0) begin
            ready_run <= ready_run - 1;
        end else if (i_out_ready) begin
            i_out_ready <= 1'b0;
            ready_run <= gap_len();
        end else begin
            i_out_ready <= 1'b1;
            ready_run <= $urandom_range(0, 6);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_colour(o_colour_index);
        end
    end

    task automatic send_item(input logic kind, input logic [17:0] la, input logic [7:0] lb,
                             input logic [17:0] base, input logic [10:0] x,
                             input logic [9:0] y);
        int g;
        g = in_calm ? 0 : gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_load_address <= la;
        i_load_byte <= lb;
        i_picture_base <= base;
        i_pixel_x <= x;
        i_pixel_y <= y;
        do @(posedge i_clk); while (!o_in_ready);
        sent_items++;
        sb.note_item(kind, la, lb, base, x, y);
    endtask

    task automatic store_byte(input logic [17:0] addr, input logic [7:0] val);
        send_item(ppf_pkg::KIND_LOAD, addr, val, 18'($urandom), 11'($urandom),
                  10'($urandom));
    endtask

    // load every plane byte the pixel will read that holds nothing yet, then fetch the pixel
    task automatic fetch_pixel(input logic [17:0] base, input logic [10:0] x,
                               input logic [9:0] y);
        int unsigned n;
        int unsigned bitpos;
        longint unsigned a;
        n = sb.eff_planes();
        if (sb.regs.layout_mode <= ppf_pkg::LAYOUT_PACKED_B) begin
            for (int unsigned i = 0; i < n; i++) begin
                a = sb.plane_addr(base, x, y, i, n, bitpos);
                if (sb.holds_data(a) && !sb.written[a]) begin
                    store_byte(a[17:0], 8'($urandom));
                end
            end
        end
        send_item(ppf_pkg::KIND_FETCH, 18'($urandom), 8'($urandom), base, x, y);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.colour_q.size() != 0) @(posedge i_clk);
        repeat (48) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_cfg(idx, val);
    endtask

    task automatic apply_settings(input ppf_pkg::t_cfg s);
        settle();
        write_reg(ppf_pkg::CFG_LAYOUT_MODE, 24'(s.layout_mode));
        write_reg(ppf_pkg::CFG_PLANE_COUNT, 24'(s.plane_count));
        write_reg(ppf_pkg::CFG_ROW_BYTES, 24'(s.row_bytes));
        write_reg(ppf_pkg::CFG_PICTURE_ROWS, 24'(s.picture_rows));
        write_reg(ppf_pkg::CFG_SKIP_BYTES, 24'(s.skip_bytes));
        write_reg(ppf_pkg::CFG_PLANE_FLAGS, 24'(s.plane_flags));
        write_reg(ppf_pkg::CFG_PLANE_ORDER, s.plane_order);
        write_reg(ppf_pkg::CFG_DATA_SIZE, 24'(s.data_size));
        i_cfg_valid <= 1'b0;
        in_calm = ($urandom_range(0, 3) == 0);
        out_calm = ($urandom_range(0, 3) == 0);
    endtask

    function automatic ppf_pkg::t_cfg make_settings(input logic [2:0] layout,
                                                    input logic [3:0] planes,
                                                    input logic [7:0] rb,
                                                    input logic [9:0] rows,
                                                    input logic [15:0] skip,
                                                    input logic [1:0] flags,
                                                    input logic [23:0] order,
                                                    input logic [18:0] size);
        ppf_pkg::t_cfg s;
        s.layout_mode = layout;
        s.plane_count = planes;
        s.row_bytes = rb;
        s.picture_rows = rows;
        s.skip_bytes = skip;
        s.plane_flags = flags;
        s.plane_order = order;
        s.data_size = size;
        return s;
    endfunction

    function automatic ppf_pkg::t_cfg random_settings();
        ppf_pkg::t_cfg s;
        int r;
        r = $urandom_range(0, 99);
        s.layout_mode = (r < 88) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
        r = $urandom_range(0, 99);
        if (r < 80) begin
            s.plane_count = 4'($urandom_range(1, 8));
        end else if (r < 88) begin
            s.plane_count = 4'd0;
        end else begin
            s.plane_count = 4'($urandom_range(9, 15));
        end
        case ($urandom_range(0, 3))
            0: s.row_bytes = 8'd1;
            1: s.row_bytes = 8'd255;
            2: s.row_bytes = 8'($urandom_range(1, 8));
            default: s.row_bytes = 8'($urandom_range(1, 255));
        endcase
        case ($urandom_range(0, 3))
            0: s.picture_rows = 10'd1;
            1: s.picture_rows = 10'd1023;
            2: s.picture_rows = 10'($urandom_range(1, 16));
            default: s.picture_rows = 10'($urandom_range(1, 1023));
        endcase
        case ($urandom_range(0, 3))
            0: s.skip_bytes = 16'd0;
            1: s.skip_bytes = 16'hFFFF;
            2: s.skip_bytes = 16'($urandom_range(1, 64));
            default: s.skip_bytes = 16'($urandom);
        endcase
        s.plane_flags = 2'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 15) begin
            s.plane_order = 24'hFAC688;
        end else if (r < 25) begin
            s.plane_order = 24'hFFFFFF;
        end else begin
            s.plane_order = 24'($urandom);
        end
        r = $urandom_range(0, 99);
        if (r < 10) begin
            s.data_size = 19'd0;
        end else if (r < 35) begin
            s.data_size = 19'(ppf_pkg::MEM_BYTES);
        end else if (r < 70) begin
            s.data_size = 19'($urandom_range(1, 4096));
        end else begin
            s.data_size = 19'($urandom_range(0, ppf_pkg::MEM_BYTES));
        end
        return s;
    endfunction

    task automatic random_traffic(input int count);
        int stop_at = sent_items + count;
        int r;
        logic [17:0] base;
        logic [10:0] x;
        logic [9:0] y;
        while (sent_items < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                if ($urandom_range(0, 1) == 0) begin
                    store_byte(18'($urandom_range(0, 4095)), 8'($urandom));
                end else begin
                    store_byte(18'($urandom), 8'($urandom));
                end
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    base = 18'($urandom_range(0, 2047));
                end else if (r < 80) begin
                    base = 18'(ppf_pkg::MEM_BYTES - 1 - $urandom_range(0, 15));
                end else begin
                    base = 18'($urandom);
                end
                if ($urandom_range(0, 99) < 80) begin
                    x = 11'($urandom_range(0, 63));
                    y = 10'($urandom_range(0, 15));
                end else begin
                    x = 11'($urandom_range(0, 2039));
                    y = 10'($urandom_range(0, 1022));
                end
                fetch_pixel(base, x, y);
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apply_settings(make_settings(ppf_pkg::LAYOUT_SEPARATE, 4'd8, 8'd1, 10'd1, 16'd0,
                                     2'd0, 24'hFAC688, 19'(ppf_pkg::MEM_BYTES)));
        store_byte(18'd0, 8'hFF);
        store_byte(18'(ppf_pkg::MEM_BYTES - 1), 8'h00);
        store_byte(18'd1, 8'h80);
        fetch_pixel(18'd0, 11'd0, 10'd0);
        fetch_pixel(18'(ppf_pkg::MEM_BYTES - 1), 11'd2039, 10'd1022);
        fetch_pixel(18'(ppf_pkg::MEM_BYTES - 8), 11'd7, 10'd0);

        apply_settings(make_settings(ppf_pkg::LAYOUT_INTERLEAVE, 4'd0, 8'd3, 10'd5, 16'd0,
                                     2'd0, 24'hFAC688, 19'd0));
        fetch_pixel(18'd5, 11'd3, 10'd1);

        apply_settings(make_settings(ppf_pkg::LAYOUT_PACKED_B, 4'd15, 8'd255, 10'd1023,
                                     16'hFFFF, 2'd3, 24'h000000,
                                     19'(ppf_pkg::MEM_BYTES)));
        fetch_pixel(18'd0, 11'd0, 10'd0);
        fetch_pixel(18'd100, 11'd2039, 10'd1022);

        apply_settings(make_settings(ppf_pkg::LAYOUT_PACKED_A, 4'd3, 8'd4, 10'd8, 16'd0,
                                     2'd0, 24'h0001FA, 19'd1024));
        fetch_pixel(18'd40, 11'd9, 10'd2);

        apply_settings(make_settings(3'd7, 4'd8, 8'd1, 10'd1, 16'd0, 2'd0,
                                     24'hFFFFFF, 19'(ppf_pkg::MEM_BYTES)));
        fetch_pixel(18'd0, 11'd0, 10'd0);

        apply_settings(make_settings(ppf_pkg::LAYOUT_SPRITE, 4'd4, 8'd2, 10'd3, 16'd5,
                                     2'd2, 24'hFAC688, 19'd64));
        fetch_pixel(18'd0, 11'd3, 10'd1);
        fetch_pixel(18'd2, 11'd12, 10'd2);

        for (int p = 0; p < 11; p++) begin
            apply_settings(random_settings());
            random_traffic(34);
        end

        settle();
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end
endmodule

### sim.f
sv/ppf_pkg.sv
sv/ppf_ram.sv
sv/ppf_front.sv
sv/ppf_queue.sv
sv/ppf_back.sv
sv/planar_pixel_fetch.sv
sim/tb.sv
